>>> hdl/bclg_pkg.sv
package bclg_pkg;

  // Field widths of the sample and result items.
  localparam int unsigned VOLT_W  = 15;
  localparam int unsigned SENSE_W = 16;
  localparam int unsigned PCT_W   = 7;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Default depth of the level history.
  localparam int unsigned WINDOW_DEFAULT = 8;

  // Shared bit-serial divider: numerator width and quotient bits.
  localparam int unsigned NUM_W = 22;
  localparam int unsigned QUO_W = 7;
  localparam int unsigned CNT_W = 3;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SHUNT_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHUNT_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_VOLT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_VOLT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_OFS   = 3'd6;

  // Register reset values.
  localparam logic signed [SENSE_W-1:0] SHUNT_LOW_RST    = 16'sd400;
  localparam logic signed [SENSE_W-1:0] SHUNT_HIGH_RST   = 16'sd32000;
  localparam logic signed [SENSE_W-1:0] CURRENT_LOW_RST  = 16'sd3;
  localparam logic signed [SENSE_W-1:0] CURRENT_HIGH_RST = 16'sd60;
  localparam logic [VOLT_W-1:0]         EMPTY_VOLT_RST   = 15'd9000;
  localparam logic [VOLT_W-1:0]         FULL_VOLT_RST    = 15'd12600;
  localparam logic [VOLT_W-1:0]         CHARGE_OFS_RST   = 15'd0;

  // Sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PREP = 6'b000010,
    ST_DIV1 = 6'b000100,
    ST_SUM  = 6'b001000,
    ST_DIV2 = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

endpackage

>>> hdl/bclg_in_if.sv
interface bclg_in_if
  import bclg_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [VOLT_W-1:0]         bus_millivolts;
  logic signed [SENSE_W-1:0] shunt_reading;
  logic signed [SENSE_W-1:0] current_milliamps;

  modport source (
    output valid, bus_millivolts, shunt_reading, current_milliamps,
    input  ready
  );
  modport sink (
    input  valid, bus_millivolts, shunt_reading, current_milliamps,
    output ready
  );
endinterface

>>> hdl/bclg_out_if.sv
interface bclg_out_if
  import bclg_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             charging;
  logic             charging_changed;
  logic [PCT_W-1:0] level_percent;

  modport source (
    output valid, charging, charging_changed, level_percent,
    input  ready
  );
  modport sink (
    input  valid, charging, charging_changed, level_percent,
    output ready
  );
endinterface

>>> hdl/battery_charge_and_level_gauge_unit.sv
// From the input transfer the sequencer steps through prepare, a bit-serial percent
// divide (skipped when the level clamps or is zero), sum, average divide and done.
// A new sample is taken only after the result is handed over; the shared divider
// yields one quotient bit per cycle and runs once or twice per sample.
// Reset (rst, synchronous, active high) loads the register defaults and clears the
// charge flag, the history fill, pointer and sum; the history memory is not cleared.
module battery_charge_and_level_gauge_unit
  import bclg_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  bclg_in_if.sink               in_ch,
  bclg_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = $clog2(WINDOW * 100 + 1);
  localparam int unsigned DIFF_W = VOLT_W + 3;

  // Configuration registers.
  logic signed [SENSE_W-1:0] shunt_low;
  logic signed [SENSE_W-1:0] shunt_high;
  logic signed [SENSE_W-1:0] current_low;
  logic signed [SENSE_W-1:0] current_high;
  logic [VOLT_W-1:0]         empty_volt;
  logic [VOLT_W-1:0]         full_volt;
  logic [VOLT_W-1:0]         charge_ofs;

  // Sample state.
  state_t                    state;
  logic                      charge_flag;
  logic                      changed;
  logic signed [DIFF_W-1:0]  diff;
  logic [PCT_W-1:0]          pct;
  logic [PCT_W-1:0]          rd_data;
  logic [PTR_W-1:0]          ptr;
  logic [FILL_W-1:0]         fill;
  logic [SUM_W-1:0]          sum;
  logic [PCT_W-1:0]          hist [WINDOW];

  // Shared divider.
  logic [NUM_W-1:0]          rem;
  logic [NUM_W-1:0]          dvs;
  logic [QUO_W-1:0]          quo;
  logic [CNT_W-1:0]          cnt;

  // Output register.
  logic                      out_valid;
  logic                      out_charging;
  logic                      out_changed;
  logic [PCT_W-1:0]          out_level;

  // Combinational terms.
  logic                      in_xfer;
  logic                      out_load;
  logic                      now_c;
  logic signed [DIFF_W-1:0]  adj_c;
  logic signed [DIFF_W-1:0]  range_c;
  logic                      take_c;
  logic [QUO_W-1:0]          quo_next;
  logic                      hist_full;
  logic [SUM_W-1:0]          sum_next;
  logic [FILL_W-1:0]         fill_next;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // The result is loaded once the output register is free or being emptied.
  assign out_load = (state == ST_DONE) && (!out_valid || out_ch.ready);

  // Strict window test on shunt voltage and current.
  assign now_c = (in_ch.shunt_reading > shunt_low) && (in_ch.shunt_reading < shunt_high)
              && (in_ch.current_milliamps > current_low)
              && (in_ch.current_milliamps < current_high);

  // Bus voltage less the offset while charging, relative to the empty point.
  assign adj_c = $signed({3'b000, in_ch.bus_millivolts})
               - $signed({3'b000, (now_c ? charge_ofs : VOLT_W'(0))})
               - $signed({3'b000, empty_volt});
  assign range_c = $signed({3'b000, full_volt}) - $signed({3'b000, empty_volt});

  // One restoring divide step: a quotient bit per cycle.
  assign take_c   = (rem >= dvs);
  assign quo_next = {quo[QUO_W-2:0], take_c};

  // Running sum update; the oldest entry drops out once the history is full.
  assign hist_full = (fill == FILL_W'(WINDOW));
  always_comb begin
    if (hist_full) begin
      sum_next  = sum - SUM_W'(rd_data) + SUM_W'(pct);
      fill_next = fill;
    end else begin
      sum_next  = sum + SUM_W'(pct);
      fill_next = fill + FILL_W'(1);
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      shunt_low    <= SHUNT_LOW_RST;
      shunt_high   <= SHUNT_HIGH_RST;
      current_low  <= CURRENT_LOW_RST;
      current_high <= CURRENT_HIGH_RST;
      empty_volt   <= EMPTY_VOLT_RST;
      full_volt    <= FULL_VOLT_RST;
      charge_ofs   <= CHARGE_OFS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHUNT_LOW:    shunt_low    <= $signed(cfg_data);
        REG_SHUNT_HIGH:   shunt_high   <= $signed(cfg_data);
        REG_CURRENT_LOW:  current_low  <= $signed(cfg_data);
        REG_CURRENT_HIGH: current_high <= $signed(cfg_data);
        REG_EMPTY_VOLT:   empty_volt   <= cfg_data[VOLT_W-1:0];
        REG_FULL_VOLT:    full_volt    <= cfg_data[VOLT_W-1:0];
        REG_CHARGE_OFS:   charge_ofs   <= cfg_data[VOLT_W-1:0];
        default: ;
      endcase
    end
  end

  // History memory: read the slot at input transfer, write it back in the sum step.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_data <= hist[ptr];
    end
    if (state == ST_SUM) begin
      hist[ptr] <= pct;
    end
  end

  // Sequencer with the shared divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      charge_flag <= 1'b0;
      ptr         <= '0;
      fill        <= '0;
      sum         <= '0;
      out_valid   <= 1'b0;
    end else begin
      // The output register fills from the done step and empties on a transfer.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            charge_flag <= now_c;
            changed     <= now_c ^ charge_flag;
            diff        <= adj_c;
            state       <= ST_PREP;
          end
        end
        ST_PREP: begin
          // Degenerate range or at/below empty reads zero; at/above full clamps.
          if ((range_c <= 0) || (diff <= 0)) begin
            pct   <= '0;
            state <= ST_SUM;
          end else if (diff >= range_c) begin
            pct   <= PCT_MAX;
            state <= ST_SUM;
          end else begin
            rem   <= NUM_W'(diff[VOLT_W-1:0]) * NUM_W'(PCT_MAX);
            dvs   <= NUM_W'(range_c[VOLT_W-1:0]) << (QUO_W - 1);
            quo   <= '0;
            cnt   <= CNT_W'(QUO_W - 1);
            state <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (take_c) begin
            rem <= rem - dvs;
          end
          dvs <= dvs >> 1;
          quo <= quo_next;
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            pct   <= quo_next;
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          // Fold the new percent into the history, then average over the fill.
          sum   <= sum_next;
          fill  <= fill_next;
          ptr   <= (ptr == PTR_W'(WINDOW - 1)) ? '0 : ptr + PTR_W'(1);
          rem   <= NUM_W'(sum_next);
          dvs   <= NUM_W'(fill_next) << (QUO_W - 1);
          quo   <= '0;
          cnt   <= CNT_W'(QUO_W - 1);
          state <= ST_DIV2;
        end
        ST_DIV2: begin
          if (take_c) begin
            rem <= rem - dvs;
          end
          dvs <= dvs >> 1;
          quo <= quo_next;
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Hand over once the output register is free or being emptied.
          if (out_load) begin
            out_charging <= charge_flag;
            out_changed  <= changed;
            out_level    <= quo;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.charging         = out_charging;
  assign out_ch.charging_changed = out_changed;
  assign out_ch.level_percent    = out_level;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state is not one-hot");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(WINDOW))
    else $error("history fill exceeds the window");
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    (SUM_W + 1)'(sum) <= (SUM_W + 1)'(fill) * (SUM_W + 1)'(PCT_MAX))
    else $error("history sum exceeds 100 per valid entry");
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_level <= PCT_MAX))
    else $error("level percent above 100");
  a_xfer_starts: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == ST_PREP))
    else $error("input transfer did not start the sequencer");
`endif

endmodule
